FILE: rtl/dfsvo_pkg.sv
// Shared constants and control types for the depth first visit order unit.
package dfsvo_pkg;

  localparam int NODES_DEFAULT = 8;
  localparam int VTX_W         = 3;
  localparam int ADJ_W         = 64;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic load;
    logic push;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic start_ok;
    logic found;
    logic last;
  } status_t;

endpackage

FILE: rtl/dfsvo_ctrl.sv
// Controller state machine for the depth first visit order unit.
module dfsvo_ctrl
  import dfsvo_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && status.start_ok) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (!status.found && status.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.load = start && status.start_ok;
      end
      ST_WALK: begin
        busy     = 1'b1;
        cmd.push = status.found;
        cmd.pop  = !status.found;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/dfsvo_datapath.sv
// Datapath: adjacency register, walk stack, visited marks and result register.
module dfsvo_datapath
  import dfsvo_pkg::*;
#(
  parameter int NODES = NODES_DEFAULT
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic [ADJ_W-1:0] cfg_write_data,
  input  logic [VTX_W-1:0] start_vertex,
  input  cmd_t             cmd,
  output status_t          status,
  output logic             result_strobe,
  output logic [VTX_W-1:0] visited_vertex,
  output logic             walk_done
);

  localparam int MAT_W = NODES * NODES;
  localparam int COL_W = $clog2(NODES + 1);
  localparam int DEP_W = $clog2(NODES + 1);
  localparam int IDX_W = $clog2(NODES);

  logic [MAT_W-1:0] adj;
  logic [NODES-1:0] visited;
  logic [DEP_W-1:0] depth;
  logic [VTX_W-1:0] pending;

  logic [VTX_W-1:0] stack_vtx [NODES];
  logic [COL_W-1:0] stack_col [NODES];

  logic [IDX_W-1:0] top_idx;
  logic [IDX_W-1:0] push_idx;
  logic [VTX_W-1:0] top_vtx;
  logic [COL_W-1:0] top_col;
  logic [NODES-1:0] row;
  logic [NODES-1:0] cand;
  logic [VTX_W-1:0] found_vtx;
  logic             found;

  assign top_idx  = IDX_W'(depth - DEP_W'(1));
  assign push_idx = depth[IDX_W-1:0];
  assign top_vtx  = stack_vtx[top_idx];
  assign top_col  = stack_col[top_idx];
  assign row      = adj[top_vtx * NODES +: NODES];

  // Unvisited neighbours at or past the resume column, self edge masked.
  always_comb begin
    for (int j = 0; j < NODES; j++) begin
      cand[j] = row[j] && !visited[j] && (VTX_W'(j) != top_vtx) &&
                (COL_W'(j) >= top_col);
    end
  end

  // Lowest index wins.
  always_comb begin
    found_vtx = '0;
    found     = 1'b0;
    for (int j = NODES - 1; j >= 0; j--) begin
      if (cand[j]) begin
        found_vtx = VTX_W'(j);
        found     = 1'b1;
      end
    end
  end

  assign status.start_ok = 32'(start_vertex) < NODES;
  assign status.found    = found;
  assign status.last     = depth == DEP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      adj <= '0;
    end else if (cfg_write_en) begin
      adj <= cfg_write_data[MAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth         <= '0;
      visited       <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (cmd.load) begin
        depth   <= DEP_W'(1);
        visited <= NODES'(1) << start_vertex;
      end else if (cmd.push) begin
        depth         <= depth + DEP_W'(1);
        visited       <= visited | (NODES'(1) << found_vtx);
        result_strobe <= 1'b1;
      end else if (cmd.pop) begin
        depth <= depth - DEP_W'(1);
        if (depth == DEP_W'(1)) result_strobe <= 1'b1;
      end
    end
  end

  // Stack entries and result payload carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stack_vtx[0] <= start_vertex;
      stack_col[0] <= '0;
      pending      <= start_vertex;
    end else if (cmd.push) begin
      stack_col[top_idx]  <= COL_W'(found_vtx) + COL_W'(1);
      stack_vtx[push_idx] <= found_vtx;
      stack_col[push_idx] <= '0;
      pending             <= found_vtx;
      visited_vertex      <= pending;
      walk_done           <= 1'b0;
    end else if (cmd.pop && depth == DEP_W'(1)) begin
      visited_vertex <= pending;
      walk_done      <= 1'b1;
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    32'(depth) <= NODES)
    else $error("stack depth above vertex count");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> 32'(depth) < NODES)
    else $error("push with a full stack");

  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    result_strobe && walk_done |-> depth == '0)
    else $error("final beat while stack still live");

  a_load_mark: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> $onehot(visited))
    else $error("walk did not start with a single visited mark");

endmodule

FILE: rtl/dfs_visit_order_unit.sv
// Top level of the depth first visit order unit.
//
//  Channel   Direction  Signals                          Beat taken when
//  --------  ---------  -------------------------------  -----------------------
//  config    in         cfg_write_en, cfg_write_data     cfg_write_en high
//  command   in         start, start_vertex, busy(out)   start high, busy low
//  result    out        result_strobe, visited_vertex,   result_strobe high
//                       walk_done
//
// A walk keeps busy high from the accepting edge until the stack empties. The
// pace is set by the stack: each cycle of the walk either pushes one newly
// found neighbour or pops one exhausted vertex. A start vertex of NODES or more
// is not accepted and yields no beat.
// Each result beat shows in the cycle after the push or pop that releases it, so
// the final beat (walk_done high) appears in the first cycle with busy low.
// Reset is synchronous and active high; it clears the adjacency matrix, the
// stack depth and the visited marks. The receiver cannot stall result beats.
module dfs_visit_order_unit
  import dfsvo_pkg::*;
#(
  parameter int NODES = NODES_DEFAULT
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic [ADJ_W-1:0] cfg_write_data,
  input  logic             start,
  input  logic [VTX_W-1:0] start_vertex,
  output logic             busy,
  output logic             result_strobe,
  output logic [VTX_W-1:0] visited_vertex,
  output logic             walk_done
);

  cmd_t    cmd;
  status_t status;

  // The controller only sequences load, push and pop; the datapath holds all
  // graph and walk state and reports whether a neighbour was found and whether
  // the stack is down to its last entry.
  dfsvo_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath delays each vertex by one find so that the last vertex of the
  // walk can carry walk_done when the stack finally empties.
  dfsvo_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .start_vertex   (start_vertex),
    .cmd            (cmd),
    .status         (status),
    .result_strobe  (result_strobe),
    .visited_vertex (visited_vertex),
    .walk_done      (walk_done)
  );

endmodule
